FILE: hdl/fir_modulate_fir_scrambler_core_defines.svh
// assertion macros for the scrambler core
// expects signals named clock and reset in the module that uses them
`ifndef FIR_MODULATE_FIR_SCRAMBLER_CORE_DEFINES_SVH
`define FIR_MODULATE_FIR_SCRAMBLER_CORE_DEFINES_SVH

// same-cycle implication
`define FMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/fms_pkg.sv
// shared types, constants and tables for the scrambler core
// no dependencies
package fms_pkg;

   localparam int TAPS      = 129;
   localparam int ROM_LEN   = 129;
   localparam int ADDR_W    = $clog2(TAPS);
   localparam int CNT_W     = $clog2(TAPS + 2);
   localparam int ROM_AW    = $clog2(ROM_LEN);
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int ACC_W     = 32;
   localparam int MUL_W     = 17;
   localparam int PROD_W    = 2 * MUL_W;

   localparam logic [CSR_IDX_W-1:0] REG_MODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = CSR_IDX_W'(1);

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

   localparam logic signed [SAMPLE_W-1:0] CARRIER_POS = 16'sd28377;
   localparam logic signed [SAMPLE_W-1:0] CARRIER_NEG = -16'sd28377;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIR1,
      ST_MOD,
      ST_MODW,
      ST_FIR2,
      ST_GAIN,
      ST_GAINW,
      ST_OUT
   } fms_state_type;

   localparam logic signed [15:0] COEF_ROM [ROM_LEN] = '{
      16'sd16, -16'sd20, -16'sd4, 16'sd6, -16'sd20, 16'sd11, 16'sd2, -16'sd22, 16'sd26,
      -16'sd12, -16'sd16, 16'sd36, -16'sd33, 16'sd3, 16'sd35, -16'sd53, 16'sd34, 16'sd15,
      -16'sd61, 16'sd69, -16'sd25, -16'sd45, 16'sd93, -16'sd77, 16'sd0, 16'sd89, -16'sd124,
      16'sd70, 16'sd45, -16'sd143, 16'sd148, -16'sd41, -16'sd111, 16'sd202, -16'sd153,
      -16'sd18, 16'sd200, -16'sd257, 16'sd128, 16'sd116, -16'sd307, 16'sd294, -16'sd58,
      -16'sd257, 16'sd425, -16'sd296, -16'sd77, 16'sd451, -16'sd544, 16'sd237, 16'sd306,
      -16'sd716, 16'sd654, -16'sd70, -16'sd701, 16'sd1109, -16'sd742, -16'sd339,
      16'sd1521, -16'sd1903, 16'sd799, 16'sd1808, -16'sd5141, 16'sd7927, 16'sd23757,
      16'sd7927, -16'sd5141, 16'sd1808, 16'sd799, -16'sd1903, 16'sd1521, -16'sd339,
      -16'sd742, 16'sd1109, -16'sd701, -16'sd70, 16'sd654, -16'sd716, 16'sd306, 16'sd237,
      -16'sd544, 16'sd451, -16'sd77, -16'sd296, 16'sd425, -16'sd257, -16'sd58, 16'sd294,
      -16'sd307, 16'sd116, 16'sd128, -16'sd257, 16'sd200, -16'sd18, -16'sd153, 16'sd202,
      -16'sd111, -16'sd41, 16'sd148, -16'sd143, 16'sd45, 16'sd70, -16'sd124, 16'sd89,
      16'sd0, -16'sd77, 16'sd93, -16'sd45, -16'sd25, 16'sd69, -16'sd61, 16'sd15, 16'sd34,
      -16'sd53, 16'sd35, 16'sd3, -16'sd33, 16'sd36, -16'sd16, -16'sd12, 16'sd26, -16'sd22,
      16'sd2, 16'sd11, -16'sd20, 16'sd6, -16'sd4, -16'sd20, 16'sd16
   };

   // taps past the table read as zero
   function automatic logic signed [15:0] fms_coef(input logic [CNT_W-1:0] idx);
      logic signed [15:0] c;
      c = 16'sd0;
      if (int'(idx) < ROM_LEN) begin
         c = COEF_ROM[ROM_AW'(idx)];
      end
      return c;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] fms_carrier(input logic [1:0] ph);
      logic signed [SAMPLE_W-1:0] c;
      case (ph)
         2'd1: begin
            c = CARRIER_POS;
         end
         2'd2: begin
            c = CARRIER_NEG;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/fms_if.sv
// valid/ready channel interfaces for the scrambler core
// depends on fms_pkg
interface fms_req_if;
   import fms_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] in_left;
   logic signed [SAMPLE_W-1:0] in_right;
   logic                       block_start;
   modport source (output valid, in_left, in_right, block_start, input ready);
   modport sink   (input valid, in_left, in_right, block_start, output ready);
endinterface

interface fms_rsp_if;
   import fms_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;
   modport source (output valid, out_left, out_right, input ready);
   modport sink   (input valid, out_left, out_right, output ready);
endinterface

interface fms_csr_if;
   import fms_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/fir_modulate_fir_scrambler_core.sv
// scrambler core: passthrough or filter, modulate, filter, gain on the left sample
// depends on fms_pkg, fms_if and fir_modulate_fir_scrambler_core_defines.svh
//
// Usage
//   req_if carries one stereo word (in_left, in_right, block_start); rsp_if returns
//   one word (out_left, out_right) for each. csr_if writes mode (index 0) and gain
//   (index 1, unsigned Q8.8); it is always ready and is to be written only while
//   the core idles, which the core does not enforce. Passthrough: the word goes
//   to a result register, then to the output register when free. Scramble: one
//   17x17 multiplier is shared by both filters, the carrier product and the gain;
//   one 32-bit accumulator serves both filters. Each filter walks TAPS taps
//   through a delay-line memory with a registered read and a registered product.
//   A new word is taken in the cycle after the previous result is loaded, never
//   earlier: req_if.ready is high only while the sequencer is idle.
//   The result sits in an output register; a stalled receiver holds it, and a
//   following scramble word runs until its own result waits for that register.
//   Reset clears the delay lines through per-entry valid bits, the carrier phase,
//   mode (passthrough) and gain (1.0); no clearing pass is needed.
`include "fir_modulate_fir_scrambler_core_defines.svh"

module fir_modulate_fir_scrambler_core (
   input logic    clock,
   input logic    reset,
   fms_req_if.sink   req_if,
   fms_rsp_if.source rsp_if,
   fms_csr_if.sink   csr_if
);
   import fms_pkg::*;

   fms_state_type state_ff, state_in;

   logic                       mode_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic [1:0]                 phase_ff, phase_in;
   logic [1:0]                 car_sel_ff, car_sel_in;
   logic [ADDR_W-1:0]          wp_ff, wp_in;
   logic [ADDR_W-1:0]          raddr_ff, raddr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           rd_tap_ff, rd_tap_in;
   logic                       rd_en_ff, rd_en_in;
   logic                       prod_en_ff, prod_en_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] res_left_ff, res_left_in;
   logic signed [SAMPLE_W-1:0] res_right_ff, res_right_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;

   logic signed [SAMPLE_W-1:0] input_line_ff [TAPS];
   logic signed [SAMPLE_W-1:0] mod_line_ff [TAPS];
   logic [TAPS-1:0]            vld1_ff, vld2_ff;
   logic signed [SAMPLE_W-1:0] rd1_ff, rd2_ff;
   logic                       rv1_ff, rv2_ff;

   logic                       wr1_en, wr2_en;
   logic signed [SAMPLE_W-1:0] wr2_data;
   logic                       req_take, out_free;
   logic [ADDR_W-1:0]          wp_next, raddr_dec;
   logic signed [SAMPLE_W-1:0] filt, tap, coef, car;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic [1:0]                 ph_sel;
   logic signed [PROD_W-9:0]   scaled;

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign csr_if.ready    = 1'b1;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_left = rsp_left_ff;
   assign rsp_if.out_right = rsp_right_ff;

   assign req_take  = req_if.valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign wp_next   = (wp_ff == ADDR_W'(TAPS - 1)) ? '0 : wp_ff + 1'b1;
   assign raddr_dec = (raddr_ff == '0) ? ADDR_W'(TAPS - 1) : raddr_ff - 1'b1;
   assign filt      = acc_ff[30:15];
   assign coef      = fms_coef(rd_tap_ff);
   assign car       = fms_carrier(car_sel_ff);
   assign tap       = (state_ff == ST_FIR2) ? (rv2_ff ? rd2_ff : '0)
                                            : (rv1_ff ? rd1_ff : '0);
   assign wr2_data  = prod_ff[30:15];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = mode_ff ? ST_FIR1 : ST_OUT;
            end
         end
         ST_FIR1: begin
            if (cnt_ff == CNT_W'(TAPS + 1)) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            state_in = ST_MODW;
         end
         ST_MODW: begin
            state_in = ST_FIR2;
         end
         ST_FIR2: begin
            if (cnt_ff == CNT_W'(TAPS + 1)) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            state_in = ST_GAINW;
         end
         ST_GAINW: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_FIR1, ST_FIR2: begin
            mul_a = {tap[SAMPLE_W-1], tap};
            mul_b = {coef[15], coef};
         end
         ST_MOD: begin
            mul_a = {car[SAMPLE_W-1], car};
            mul_b = {filt[SAMPLE_W-1], filt};
         end
         ST_GAIN: begin
            mul_a = {1'b0, gain_ff};
            mul_b = {filt[SAMPLE_W-1], filt};
         end
         default: begin
            mul_a = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // gain scaling, truncated toward zero
   always_comb begin
      scaled = prod_ff[PROD_W-1:8];
      if (prod_ff[PROD_W-1] && (prod_ff[7:0] != '0)) begin
         scaled = scaled + 1'b1;
      end
   end

   // sequencer outputs
   always_comb begin
      phase_in     = phase_ff;
      car_sel_in   = car_sel_ff;
      wp_in        = wp_ff;
      raddr_in     = raddr_ff;
      cnt_in       = cnt_ff;
      rd_tap_in    = rd_tap_ff;
      rd_en_in     = 1'b0;
      prod_en_in   = rd_en_ff;
      acc_in       = acc_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      wr1_en       = 1'b0;
      wr2_en       = 1'b0;
      ph_sel       = req_if.block_start ? 2'd0 : phase_ff;
      if (ph_sel > 2'd2) begin
         ph_sel = 2'd0;
      end
      if (prod_en_ff) begin
         acc_in = acc_ff + prod_ff[ACC_W-1:0];
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (mode_ff) begin
                  wp_in      = wp_next;
                  raddr_in   = wp_next;
                  wr1_en     = 1'b1;
                  car_sel_in = ph_sel;
                  phase_in   = (ph_sel == 2'd2) ? 2'd0 : ph_sel + 1'b1;
                  cnt_in     = '0;
                  acc_in     = '0;
               end else begin
                  res_left_in  = req_if.in_left;
                  res_right_in = req_if.in_right;
               end
            end
         end
         ST_FIR1, ST_FIR2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff < CNT_W'(TAPS)) begin
               rd_en_in  = 1'b1;
               rd_tap_in = cnt_ff;
               raddr_in  = raddr_dec;
            end
         end
         ST_MODW: begin
            wr2_en   = 1'b1;
            raddr_in = wp_ff;
            cnt_in   = '0;
            acc_in   = '0;
         end
         ST_GAINW: begin
            if (scaled > (PROD_W-8)'(32767)) begin
               res_left_in = 16'sh7fff;
            end else if (scaled < -(PROD_W-8)'(32768)) begin
               res_left_in = -16'sh8000;
            end else begin
               res_left_in = scaled[SAMPLE_W-1:0];
            end
            res_right_in = '0;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_left_ff;
               rsp_right_in = res_right_ff;
            end
         end
         default: begin
            rd_en_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         gain_ff      <= GAIN_RESET;
         phase_ff     <= '0;
         wp_ff        <= '0;
         rd_en_ff     <= 1'b0;
         prod_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld1_ff      <= '0;
         vld2_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         rd_en_ff     <= rd_en_in;
         prod_en_ff   <= prod_en_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr1_en) begin
            vld1_ff[wp_in] <= 1'b1;
         end
         if (wr2_en) begin
            vld2_ff[wp_in] <= 1'b1;
         end
         if (csr_if.valid) begin
            case (csr_if.index)
               REG_MODE: begin
                  mode_ff <= csr_if.data[0];
               end
               REG_GAIN: begin
                  gain_ff <= csr_if.data[GAIN_W-1:0];
               end
               default: begin
                  mode_ff <= mode_ff;
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      car_sel_ff   <= car_sel_in;
      raddr_ff     <= raddr_in;
      cnt_ff       <= cnt_in;
      rd_tap_ff    <= rd_tap_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   // delay line memories
   always_ff @(posedge clock) begin
      if (wr1_en) begin
         input_line_ff[wp_in] <= req_if.in_left;
      end
      if (wr2_en) begin
         mod_line_ff[wp_in] <= wr2_data;
      end
      rd1_ff <= input_line_ff[raddr_ff];
      rd2_ff <= mod_line_ff[raddr_ff];
      rv1_ff <= vld1_ff[raddr_ff];
      rv2_ff <= vld2_ff[raddr_ff];
   end

   `FMS_ASSERT_NEXT(a_pass_to_out, req_take && !mode_ff, state_ff == ST_OUT, "passthrough word did not go to output")
   `FMS_ASSERT_NOW(a_wp_range, 1'b1, wp_ff < ADDR_W'(TAPS), "write pointer out of range")
   `FMS_ASSERT_NOW(a_prod_in_fir, prod_en_ff, state_ff == ST_FIR1 || state_ff == ST_FIR2, "tap product outside filter")
   `FMS_ASSERT_NEXT(a_out_hold, state_ff == ST_OUT && rsp_valid_ff && !rsp_if.ready, state_ff == ST_OUT, "result overwrote a stalled word")

endmodule
